// ===== design/keyboard_scancode_decoder_assert.svh =====
// ----------------------------------------------------------------------------
// Keyboard scancode decoder assertion macros
// Concurrent assertion wrappers used by the decoder result stage.
// ----------------------------------------------------------------------------
`ifndef KEYBOARD_SCANCODE_DECODER_ASSERT_SVH
`define KEYBOARD_SCANCODE_DECODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define KSD_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define KSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/ksd_pkg.sv =====
// ----------------------------------------------------------------------------
// Keyboard scancode decoder package
// Shared types, codes and constants of the scancode decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package ksd_pkg;

    // Number of consoles reachable by ctrl+alt+function key
    localparam int NUM_CONSOLES = 12;

    // Keymap store geometry: four maps of 128 entries
    localparam int KM_WIDTH  = 8;
    localparam int KM_DEPTH  = 512;
    localparam int KM_ADDR_W = 9;

    // Request opcodes
    localparam logic OP_SCAN      = 1'b0;
    localparam logic OP_MAP_WRITE = 1'b1;

    // Characters of the escape sequences
    localparam logic [7:0] CH_ESC       = 8'h1b;
    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_LBRACKET  = 8'h5b;
    localparam logic [7:0] CH_TWO       = 8'h32;
    localparam logic [7:0] CH_TILDE     = 8'h7e;
    localparam logic [7:0] CH_UP        = 8'h41;
    localparam logic [7:0] CH_DOWN      = 8'h42;
    localparam logic [7:0] CH_RIGHT     = 8'h43;
    localparam logic [7:0] CH_LEFT      = 8'h44;
    localparam logic [7:0] CH_END       = 8'h46;
    localparam logic [7:0] CH_HOME      = 8'h48;

    // Console switch kinds
    typedef enum logic [1:0] {
        SW_NONE = 2'd0,
        SW_ABS  = 2'd1,
        SW_PREV = 2'd2,
        SW_NEXT = 2'd3
    } ksd_switch_t;

    // Character output kinds decided at decode
    typedef enum logic [2:0] {
        CHR_NONE = 3'd0,
        CHR_MAP  = 3'd1,
        CHR_ESC  = 3'd2,
        CHR_INS  = 3'd3,
        CHR_BS   = 3'd4
    } ksd_chr_t;

    // Decoded scancode handed from the decode stage to the result stage
    typedef struct packed {
        logic        led;
        ksd_switch_t sw_kind;
        logic [3:0]  sw_target;
        ksd_chr_t    chr;
        logic [7:0]  esc_char;
        logic        ctrl;
        logic        lalt;
        logic [2:0]  leds;
    } ksd_req_t;

    // One result item, without its last flag and LED state
    typedef struct packed {
        logic        has_char;
        logic [7:0]  char_code;
        logic        led_update;
        ksd_switch_t switch_kind;
        logic [3:0]  switch_target;
    } ksd_result_t;

endpackage

`default_nettype wire

// ===== design/keyboard_scancode_decoder.sv =====
// ----------------------------------------------------------------------------
// Keyboard scancode decoder
// PC scancode set 1 to character decoder with loadable keymaps.
// ----------------------------------------------------------------------------
// A request is taken every cycle the result buffer can drain in time; a
// scancode is registered in the decode stage and the keymap read ports,
// then in a four-entry result buffer, which sends its one to four results
// in the order LED request, console switch, characters, one result per
// cycle while m_tready is high; a byte or map write with none sends nothing.
// The keymap store is a 512-entry RAM with two registered read ports (base
// entry and selected map entry); it has no reset, so every entry must be
// written with a map write request before a scancode reads it.
`default_nettype none

module keyboard_scancode_decoder
    import ksd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // s_tdata: scan_byte[7:0], map_select[9:8], map_index[16:10],
    //          map_value[24:17], zero[31:25]
    input  wire logic [31:0] s_tdata,
    // s_tuser: opcode[0]
    input  wire logic [0:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // m_tdata: char_code[7:0], led_update[8], led_bits[11:9],
    //          switch_kind[13:12], switch_target[17:14], zero[23:18]
    output logic [23:0]      m_tdata,
    // m_tuser: has_char[0]
    output logic [0:0]       m_tuser,
    output logic             m_tlast
);

    ksd_req_t               req;
    ksd_result_t            result;
    logic                   req_valid;
    logic                   consume;
    logic [2:0]             leds;
    logic                   km_we;
    logic                   km_re;
    logic [KM_ADDR_W-1:0]   km_waddr;
    logic [KM_ADDR_W-1:0]   km_raddr_a;
    logic [KM_ADDR_W-1:0]   km_raddr_b;
    logic [KM_WIDTH-1:0]    km_wdata;
    logic [KM_WIDTH-1:0]    km_rdata_a;
    logic [KM_WIDTH-1:0]    km_rdata_b;

    // Decode scancodes and track keyboard state
    ksd_decode u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .opcode     (s_tuser[0]),
        .scan_byte  (s_tdata[7:0]),
        .map_select (s_tdata[9:8]),
        .map_index  (s_tdata[16:10]),
        .map_value  (s_tdata[24:17]),
        .consume    (consume),
        .req_valid  (req_valid),
        .req        (req),
        .km_we      (km_we),
        .km_waddr   (km_waddr),
        .km_wdata   (km_wdata),
        .km_re      (km_re),
        .km_raddr_a (km_raddr_a),
        .km_raddr_b (km_raddr_b)
    );

    // Keymap store
    ksd_ram #(
        .WIDTH (KM_WIDTH),
        .DEPTH (KM_DEPTH)
    ) u_keymap (
        .clk     (clk),
        .we      (km_we),
        .waddr   (km_waddr),
        .wdata   (km_wdata),
        .re      (km_re),
        .raddr_a (km_raddr_a),
        .raddr_b (km_raddr_b),
        .rdata_a (km_rdata_a),
        .rdata_b (km_rdata_b)
    );

    // Build and send the results
    ksd_results u_results (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req        (req),
        .base_code  (km_rdata_a),
        .sel_code   (km_rdata_b),
        .consume    (consume),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result),
        .out_leds   (leds),
        .out_last   (m_tlast)
    );

    // Pack the result fields
    assign m_tdata = {6'd0, result.switch_target, result.switch_kind, leds,
                      result.led_update, result.char_code};
    assign m_tuser = result.has_char;

endmodule

`default_nettype wire

// ===== design/ksd_ram.sv =====
// ----------------------------------------------------------------------------
// Keyboard scancode decoder RAM
// Generic RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module ksd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_a,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one entry
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Register both read ports, hold data while not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

`default_nettype wire

// ===== design/ksd_decode.sv =====
// ----------------------------------------------------------------------------
// Keyboard scancode decoder front end
// Tracks modifier, lock and prefix state, classifies each scancode and
// issues the keymap reads and writes.
// ----------------------------------------------------------------------------
`default_nettype none

module ksd_decode
    import ksd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 opcode,
    input  wire logic [7:0]           scan_byte,
    input  wire logic [1:0]           map_select,
    input  wire logic [6:0]           map_index,
    input  wire logic [7:0]           map_value,
    input  wire logic                 consume,
    output logic                      req_valid,
    output ksd_req_t                  req,
    output logic                      km_we,
    output logic [KM_ADDR_W-1:0]      km_waddr,
    output logic [KM_WIDTH-1:0]       km_wdata,
    output logic                      km_re,
    output logic [KM_ADDR_W-1:0]      km_raddr_a,
    output logic [KM_ADDR_W-1:0]      km_raddr_b
);

    // Prefix tracker states
    typedef enum logic [3:0] {
        PFX_NONE  = 4'b0001,
        PFX_E0    = 4'b0010,
        PFX_SKIP2 = 4'b0100,
        PFX_SKIP1 = 4'b1000
    } pfx_t;

    // Modifier bit positions
    localparam int M_LSHIFT = 0;
    localparam int M_RSHIFT = 1;
    localparam int M_LCTRL  = 2;
    localparam int M_RCTRL  = 3;
    localparam int M_LALT   = 4;
    localparam int M_RALT   = 5;

    // Lock bit positions
    localparam int L_SCROLL = 0;
    localparam int L_NUM    = 1;
    localparam int L_CAPS   = 2;

    logic [5:0] mod_reg,  mod_next;
    logic [2:0] lp_reg,   lp_next;
    logic [2:0] lm_reg,   lm_next;
    pfx_t       pfx_reg,  pfx_next;
    logic       valid_reg, valid_next;
    ksd_req_t   req_reg,  req_next;

    logic       in_fire;
    logic       scan_fire;
    logic       alt_ctrl;
    logic       shifted;
    logic [3:0] fkey;

    function automatic logic is_alpha(input logic [7:0] d);
        is_alpha = (d >= 8'h10 && d <= 8'h1a) || (d >= 8'h1e && d <= 8'h28) ||
                   (d >= 8'h2c && d <= 8'h32);
    endfunction

    assign in_ready  = !valid_reg || consume;
    assign in_fire   = in_valid && in_ready;
    assign scan_fire = in_fire && (opcode == OP_SCAN);

    // Keymap write on a map write request
    assign km_we    = in_fire && (opcode == OP_MAP_WRITE);
    assign km_waddr = {map_select, map_index};
    assign km_wdata = map_value;

    // Decode one scancode against the current state
    always_comb
    begin
        mod_next  = mod_reg;
        lp_next   = lp_reg;
        lm_next   = lm_reg;
        pfx_next  = pfx_reg;
        alt_ctrl  = 1'b0;
        fkey      = 4'd0;
        req_next           = req_reg;
        req_next.led       = 1'b0;
        req_next.sw_kind   = SW_NONE;
        req_next.sw_target = 4'd0;
        req_next.chr       = CHR_NONE;
        req_next.esc_char  = 8'd0;

        unique case (pfx_reg)
            PFX_E0:
            begin
                pfx_next = PFX_NONE;
                alt_ctrl = mod_reg[M_LALT] && (mod_reg[M_LCTRL] || mod_reg[M_RCTRL]);
                case (scan_byte)
                    8'h38: mod_next[M_RALT]  = 1'b1;
                    8'hb8: mod_next[M_RALT]  = 1'b0;
                    8'h1d: mod_next[M_RCTRL] = 1'b1;
                    8'h9d: mod_next[M_RCTRL] = 1'b0;
                    8'h48:
                    begin
                        req_next.chr      = CHR_ESC;
                        req_next.esc_char = CH_UP;
                    end
                    8'h50:
                    begin
                        req_next.chr      = CHR_ESC;
                        req_next.esc_char = CH_DOWN;
                    end
                    8'h47:
                    begin
                        req_next.chr      = CHR_ESC;
                        req_next.esc_char = CH_HOME;
                    end
                    8'h4f:
                    begin
                        req_next.chr      = CHR_ESC;
                        req_next.esc_char = CH_END;
                    end
                    8'h4b:
                    begin
                        if (alt_ctrl)
                        begin
                            req_next.sw_kind = SW_PREV;
                        end
                        else
                        begin
                            req_next.chr      = CHR_ESC;
                            req_next.esc_char = CH_LEFT;
                        end
                    end
                    8'h4d:
                    begin
                        if (alt_ctrl)
                        begin
                            req_next.sw_kind = SW_NEXT;
                        end
                        else
                        begin
                            req_next.chr      = CHR_ESC;
                            req_next.esc_char = CH_RIGHT;
                        end
                    end
                    8'h52: req_next.chr = CHR_INS;
                    8'h53: req_next.chr = CHR_BS;
                    default: ;
                endcase
            end
            PFX_SKIP2: pfx_next = PFX_SKIP1;
            PFX_SKIP1: pfx_next = PFX_NONE;
            default:
            begin
                if (scan_byte == 8'he0)
                begin
                    pfx_next = PFX_E0;
                end
                else if (scan_byte == 8'he1)
                begin
                    pfx_next = PFX_SKIP2;
                end
                else
                begin
                    // Modifier and lock keys
                    case (scan_byte)
                        8'h38: mod_next[M_LALT]   = 1'b1;
                        8'hb8: mod_next[M_LALT]   = 1'b0;
                        8'h1d: mod_next[M_LCTRL]  = 1'b1;
                        8'h9d: mod_next[M_LCTRL]  = 1'b0;
                        8'h2a: mod_next[M_LSHIFT] = 1'b1;
                        8'haa: mod_next[M_LSHIFT] = 1'b0;
                        8'h36: mod_next[M_RSHIFT] = 1'b1;
                        8'hb6: mod_next[M_RSHIFT] = 1'b0;
                        8'h45:
                        begin
                            lm_next[L_NUM] = lm_reg[L_NUM] ^ !lp_reg[L_NUM];
                            lp_next[L_NUM] = 1'b1;
                            req_next.led   = 1'b1;
                        end
                        8'hc5: lp_next[L_NUM] = 1'b0;
                        8'h46:
                        begin
                            lm_next[L_SCROLL] = lm_reg[L_SCROLL] ^ !lp_reg[L_SCROLL];
                            lp_next[L_SCROLL] = 1'b1;
                            req_next.led      = 1'b1;
                        end
                        8'hc6: lp_next[L_SCROLL] = 1'b0;
                        8'h3a:
                        begin
                            lm_next[L_CAPS] = lm_reg[L_CAPS] ^ !lp_reg[L_CAPS];
                            lp_next[L_CAPS] = 1'b1;
                            req_next.led    = 1'b1;
                        end
                        8'hba: lp_next[L_CAPS] = 1'b0;
                        default: ;
                    endcase

                    // Function keys with ctrl+alt select a console
                    alt_ctrl = mod_next[M_LALT] && (mod_next[M_LCTRL] || mod_next[M_RCTRL]);
                    if (scan_byte >= 8'h3b && scan_byte <= 8'h44)
                    begin
                        fkey = 4'(scan_byte - 8'h3a);
                    end
                    else if (scan_byte == 8'h57 || scan_byte == 8'h58)
                    begin
                        fkey = 4'(scan_byte - 8'h4c);
                    end
                    if (fkey != 4'd0 && alt_ctrl && fkey <= 4'(NUM_CONSOLES))
                    begin
                        req_next.sw_kind   = SW_ABS;
                        req_next.sw_target = fkey - 4'd1;
                    end

                    // Make codes go through the keymaps
                    if (!scan_byte[7])
                    begin
                        req_next.chr = CHR_MAP;
                    end
                end
            end
        endcase

        req_next.ctrl = mod_next[M_LCTRL] || mod_next[M_RCTRL];
        req_next.lalt = mod_next[M_LALT];
        req_next.leds = lm_next;
    end

    // Keymap reads: base entry and the selected map entry
    assign shifted    = mod_next[M_LSHIFT] || mod_next[M_RSHIFT] ||
                        (lm_next[L_CAPS] && is_alpha(scan_byte));
    assign km_re      = scan_fire;
    assign km_raddr_a = {2'b00, scan_byte[6:0]};
    assign km_raddr_b = {mod_next[M_RALT], shifted, scan_byte[6:0]};

    // Hold the decoded request until the result stage takes it
    always_comb
    begin
        valid_next = valid_reg;
        if (in_fire)
        begin
            valid_next = scan_fire;
        end
        else if (consume)
        begin
            valid_next = 1'b0;
        end
    end

    // Advance state on each accepted scancode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mod_reg   <= 6'd0;
            lp_reg    <= 3'd0;
            lm_reg    <= 3'd0;
            pfx_reg   <= PFX_NONE;
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (scan_fire)
            begin
                mod_reg <= mod_next;
                lp_reg  <= lp_next;
                lm_reg  <= lm_next;
                pfx_reg <= pfx_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan_fire)
        begin
            req_reg <= req_next;
        end
    end

    assign req_valid = valid_reg;
    assign req       = req_reg;

endmodule

`default_nettype wire

// ===== design/ksd_results.sv =====
// ----------------------------------------------------------------------------
// Keyboard scancode decoder result stage
// Builds the result list of one decoded scancode and sends it one item
// per cycle while out_ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

`include "keyboard_scancode_decoder_assert.svh"

module ksd_results
    import ksd_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    input  wire ksd_req_t            req,
    input  wire logic [KM_WIDTH-1:0] base_code,
    input  wire logic [KM_WIDTH-1:0] sel_code,
    output logic                     consume,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output ksd_result_t              out_result,
    output logic [2:0]               out_leds,
    output logic                     out_last
);

    ksd_result_t res [4];
    logic [2:0]  cnt;
    logic [7:0]  map_char;

    ksd_result_t job_res_reg [4];
    logic        job_valid_reg, job_valid_next;
    logic [1:0]  job_ptr_reg,   job_ptr_next;
    logic [1:0]  job_last_reg;
    logic [2:0]  job_leds_reg;

    logic        job_free;
    logic        load;
    logic        out_fire;

    // Translate the keymap entries
    always_comb
    begin
        map_char = req.ctrl ? (base_code & 8'h1f) : sel_code;
        if (req.lalt)
        begin
            map_char = map_char ^ 8'h80;
        end
    end

    // Build the result list in output order
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            res[i] = '{has_char: 1'b0, char_code: 8'd0, led_update: 1'b0,
                       switch_kind: SW_NONE, switch_target: 4'd0};
        end
        cnt = 3'd0;
        if (req.led)
        begin
            res[cnt[1:0]].led_update = 1'b1;
            cnt = cnt + 3'd1;
        end
        if (req.sw_kind != SW_NONE)
        begin
            res[cnt[1:0]].switch_kind   = req.sw_kind;
            res[cnt[1:0]].switch_target = req.sw_target;
            cnt = cnt + 3'd1;
        end
        unique case (req.chr)
            CHR_MAP:
            begin
                if (base_code != 8'd0)
                begin
                    res[cnt[1:0]].has_char  = 1'b1;
                    res[cnt[1:0]].char_code = map_char;
                    cnt = cnt + 3'd1;
                end
            end
            CHR_ESC:
            begin
                res[0].has_char  = 1'b1;
                res[0].char_code = CH_ESC;
                res[1].has_char  = 1'b1;
                res[1].char_code = CH_LBRACKET;
                res[2].has_char  = 1'b1;
                res[2].char_code = req.esc_char;
                cnt = 3'd3;
            end
            CHR_INS:
            begin
                res[0].has_char  = 1'b1;
                res[0].char_code = CH_ESC;
                res[1].has_char  = 1'b1;
                res[1].char_code = CH_LBRACKET;
                res[2].has_char  = 1'b1;
                res[2].char_code = CH_TWO;
                res[3].has_char  = 1'b1;
                res[3].char_code = CH_TILDE;
                cnt = 3'd4;
            end
            CHR_BS:
            begin
                res[0].has_char  = 1'b1;
                res[0].char_code = CH_BACKSPACE;
                cnt = 3'd1;
            end
            default: ;
        endcase
    end

    // Take the request once the result buffer drains, or at once if it has no results
    assign out_fire = job_valid_reg && out_ready;
    assign job_free = !job_valid_reg || (out_ready && job_ptr_reg == job_last_reg);
    assign consume  = req_valid && (cnt == 3'd0 || job_free);
    assign load     = req_valid && cnt != 3'd0 && job_free;

    // Advance through the result buffer
    always_comb
    begin
        job_valid_next = job_valid_reg;
        job_ptr_next   = job_ptr_reg;
        if (load)
        begin
            job_valid_next = 1'b1;
            job_ptr_next   = 2'd0;
        end
        else if (out_fire)
        begin
            if (job_ptr_reg == job_last_reg)
            begin
                job_valid_next = 1'b0;
            end
            else
            begin
                job_ptr_next = job_ptr_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            job_ptr_reg   <= 2'd0;
        end
        else
        begin
            job_valid_reg <= job_valid_next;
            job_ptr_reg   <= job_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            job_res_reg  <= res;
            job_last_reg <= 2'(cnt - 3'd1);
            job_leds_reg <= req.leds;
        end
    end

    assign out_valid  = job_valid_reg;
    assign out_result = job_res_reg[job_ptr_reg];
    assign out_leds   = job_leds_reg;
    assign out_last   = job_ptr_reg == job_last_reg;

    `KSD_ASSERT_IMPLY(a_ptr_range, clk, rst_n, job_valid_reg, job_ptr_reg <= job_last_reg, "result pointer beyond list")
    `KSD_ASSERT_NEXT(a_load_start, clk, rst_n, load, job_valid_reg && job_ptr_reg == 2'd0, "result list not started")
    `KSD_ASSERT_NEXT(a_no_drop, clk, rst_n, out_fire && !out_last, job_valid_reg && job_ptr_reg == $past(job_ptr_reg) + 2'd1, "result list cut short")
    `KSD_ASSERT_NEXT(a_stall_hold, clk, rst_n, job_valid_reg && !out_ready, job_valid_reg && $stable(job_ptr_reg), "stalled result moved")
    `KSD_ASSERT_IMPLY(a_led_first, clk, rst_n, job_valid_reg && out_result.led_update, job_ptr_reg == 2'd0, "LED request not first")

endmodule

`default_nettype wire
